>>> sv/lfsa_pkg.sv
// Shared item types and field widths for the lowest free slot allocator.
package lfsa_pkg;

  localparam int TIME_W   = 32;
  localparam int ACTIVE_W = 7;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              restart;
  } in_item_t;

  typedef struct packed {
    logic               granted;
    logic [SLOT_W-1:0]  slot_index;
    logic [COUNT_W-1:0] busy_count;
  } out_item_t;

endpackage

>>> sv/lfsa_cell.sv
// One slot of the allocator chain: holds busy flag and end time, passes the request on.
module lfsa_cell #(
  parameter int SLOTS = 64,
  parameter int INDEX = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               valid_in,
  input  lfsa_pkg::in_item_t                 req_in,
  input  logic [lfsa_pkg::ACTIVE_W-1:0]      limit_in,
  input  logic                               found_in,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] pick_in,
  input  logic [$clog2(SLOTS + 1)-1:0]       count_in,
  output logic                               valid_out,
  output lfsa_pkg::in_item_t                 req_out,
  output logic [lfsa_pkg::ACTIVE_W-1:0]      limit_out,
  output logic                               found_out,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] pick_out,
  output logic [$clog2(SLOTS + 1)-1:0]       count_out
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic                        busy;
  logic [lfsa_pkg::TIME_W-1:0] end_q;
  logic                        busy_live;
  logic                        in_range;
  logic                        take;
  logic                        busy_next;

  // Restart and expiry act before the grant decision.
  assign busy_live = busy && !req_in.restart && !(end_q < req_in.start_time);
  assign in_range  = ({{(32 - lfsa_pkg::ACTIVE_W){1'b0}}, limit_in} > 32'(INDEX));
  assign take      = valid_in && !found_in && in_range && !busy_live;
  assign busy_next = busy_live || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      valid_out <= 1'b0;
    end else if (adv) begin
      valid_out <= valid_in;
      if (valid_in) begin
        busy <= busy_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        end_q <= req_in.end_time;
      end
      req_out   <= req_in;
      limit_out <= limit_in;
      found_out <= found_in || take;
      pick_out  <= take ? IW'(INDEX) : pick_in;
      count_out <= count_in + CW'(busy_next);
    end
  end

endmodule

>>> sv/lowest_free_slot_allocator.sv
// Top level of the lowest free slot allocator: request chain, handshakes, config register.
//
// Requests enter on in_valid/in_data and are accepted at an edge where in_valid is
// high and in_stall is low. Each request walks a chain of SLOTS cells, one cell per
// cycle while the chain advances; every cell frees its slot when the stored end time
// is below the request's start time (or on restart), and the first free active cell
// grants itself. One result per request appears on out_valid/out_data after passing
// through the output register of each of the SLOTS cells; a new request can enter
// every cycle while in_stall is low, since each cell sees requests in arrival order.
// Throughput is one item per cycle unless out_stall holds the chain.
// When the receiver raises out_stall while a result is shown, the whole chain holds
// and in_stall goes high until the result is taken.
// cfg_wr_en/cfg_wr_data write active_slots (reset 64); write only while idle.
// Reset (rst, synchronous) frees every slot and empties the chain; stored end times
// are left as they are and are read only for busy slots.
module lowest_free_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lfsa_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lfsa_pkg::out_item_t           out_data,
  input  logic                          cfg_wr_en,
  input  logic [lfsa_pkg::ACTIVE_W-1:0] cfg_wr_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  logic [lfsa_pkg::ACTIVE_W-1:0] active_slots;
  logic                          adv;

  logic                          wv    [SLOTS+1];
  lfsa_pkg::in_item_t            wreq  [SLOTS+1];
  logic [lfsa_pkg::ACTIVE_W-1:0] wlim  [SLOTS+1];
  logic                          wfound[SLOTS+1];
  logic [IW-1:0]                 wpick [SLOTS+1];
  logic [CW-1:0]                 wcount[SLOTS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= lfsa_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_slots <= cfg_wr_data;
    end
  end

  // Hold the chain only while a result waits and is stalled.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign wv[0]     = in_valid;
  assign wreq[0]   = in_data;
  assign wlim[0]   = active_slots;
  assign wfound[0] = 1'b0;
  assign wpick[0]  = '0;
  assign wcount[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lfsa_cell #(
      .SLOTS(SLOTS),
      .INDEX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .valid_in (wv[g]),
      .req_in   (wreq[g]),
      .limit_in (wlim[g]),
      .found_in (wfound[g]),
      .pick_in  (wpick[g]),
      .count_in (wcount[g]),
      .valid_out(wv[g+1]),
      .req_out  (wreq[g+1]),
      .limit_out(wlim[g+1]),
      .found_out(wfound[g+1]),
      .pick_out (wpick[g+1]),
      .count_out(wcount[g+1])
    );
  end

  assign out_valid           = wv[SLOTS];
  assign out_data.granted    = wfound[SLOTS];
  assign out_data.slot_index = wfound[SLOTS] ? lfsa_pkg::SLOT_W'(wpick[SLOTS]) : '0;
  assign out_data.busy_count = lfsa_pkg::COUNT_W'(wcount[SLOTS]);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(wcount[SLOTS]) <= 32'(SLOTS)))
    else $error("busy count exceeds slot count");

  a_grant_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.granted) |-> (wcount[SLOTS] != '0))
    else $error("granted item reports no busy slot");

  a_grant_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.granted) |->
      (32'(wpick[SLOTS]) < {{(32 - lfsa_pkg::ACTIVE_W){1'b0}}, wlim[SLOTS]}))
    else $error("granted slot outside active range");

endmodule
